// ----- hw/rtl/twcc_pkg.sv -----
// ----------------------------------------------------------------------------
// twcc_pkg
// Shared widths, constants and controller/datapath handshake structs for the
// tile wall circle collision core.
// ----------------------------------------------------------------------------
package twcc_pkg;

  localparam int TILE_W  = 6;
  localparam int WALLS_W = 4;
  localparam int POS_W   = 16;
  localparam int RAD_W   = 10;
  localparam int R2_W    = 2 * RAD_W;
  localparam int THICK_W = 8;

  localparam logic [THICK_W-1:0] THICK_RESET = 8'd16;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Bit positions inside a tile's wall nibble.
  localparam int WALL_N = 0;
  localparam int WALL_S = 1;
  localparam int WALL_W = 2;
  localparam int WALL_E = 3;

  typedef struct packed {
    logic clear_en;     // write zero at the clear counter and advance it
    logic accept_en;    // input channel may accept a request
    logic setup_en;     // compute tile floors and squared radius
    logic load_bounds;  // clamp scan window and preset scan counters
    logic scan_step;    // issue one tile into the test pipeline
    logic load_result;  // move the accumulated hit into the output register
  } twcc_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic empty;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } twcc_sts_t;

endpackage

// ----- hw/rtl/twcc_ifs.sv -----
// ----------------------------------------------------------------------------
// twcc channel interfaces
// Valid/ready channels for requests into and results out of the core.
// ----------------------------------------------------------------------------
interface twcc_in_if import twcc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [TILE_W-1:0]        tile_row;
  logic [TILE_W-1:0]        tile_col;
  logic [WALLS_W-1:0]       tile_walls;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_z;
  logic [RAD_W-1:0]         circle_radius;

  modport source (output valid, mode, tile_row, tile_col, tile_walls, pos_x, pos_z,
                  circle_radius, input ready);
  modport sink (input valid, mode, tile_row, tile_col, tile_walls, pos_x, pos_z,
                circle_radius, output ready);
endinterface

interface twcc_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// ----- hw/rtl/tile_wall_circle_collision_core.sv -----
// ----------------------------------------------------------------------------
// tile_wall_circle_collision_core
// Square grid of wall tiles with a circle-against-wall-slab overlap query.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (valid/ready). Mode 0 writes the four wall bits of
// one tile and returns nothing; rows or columns outside the grid are dropped.
// Mode 1 queries a circle and returns one hit flag on out_ch. A query passes
// through setup, then scans each tile in the scan window (columns and rows
// from one below floor(centre - radius) to one above floor(centre + radius),
// clipped to the grid: 3 to 7 per axis for radii up to two tiles, so up to 49
// tiles; larger radii widen it to at most 11 per axis), lets the slab test
// pipeline drain and then loads the output register, which raises
// out_ch.valid. A window that lies wholly off the grid skips the scan.
// The scan steps one tile at a time, as the wall store has a single read port.
// cfg_wr_en writes the slab half thickness; it takes effect immediately.
// After reset the store is cleared one tile per cycle, all GRID_SIZE*GRID_SIZE
// tiles, while in_ch.ready stays low. The finished result sits in an output
// register, so the next request is taken while it waits; a query that ends
// while that register is still full waits until out_ch.ready frees it.
// ----------------------------------------------------------------------------
module tile_wall_circle_collision_core import twcc_pkg::*; #(
  parameter int GRID_SIZE = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  twcc_in_if.sink            in_ch,
  twcc_out_if.source         out_ch,
  input  logic               cfg_wr_en,
  input  logic [THICK_W-1:0] cfg_wr_data
);

  twcc_cmd_t cmd;
  twcc_sts_t sts;
  logic      in_accept;

  assign in_ch.ready = cmd.accept_en;
  assign in_accept   = in_ch.valid && in_ch.ready;

  twcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  twcc_datapath #(
    .GRID_SIZE (GRID_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_accept        (in_accept),
    .in_mode          (in_ch.mode),
    .in_tile_row      (in_ch.tile_row),
    .in_tile_col      (in_ch.tile_col),
    .in_tile_walls    (in_ch.tile_walls),
    .in_pos_x         (in_ch.pos_x),
    .in_pos_z         (in_ch.pos_z),
    .in_circle_radius (in_ch.circle_radius),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_hit          (out_ch.hit)
  );

  // A result is only loaded into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> (!out_ch.valid || out_ch.ready))
    else $error("result loaded over a pending result");

  // The pipeline has settled before its accumulated hit is taken.
  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> !sts.pipe_busy)
    else $error("result loaded while tiles are still in flight");

  // No new request is taken while tiles are being scanned.
  a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !in_ch.ready)
    else $error("input ready during scan");

  // A query request closes the input until its result is produced.
  a_query_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.mode == MODE_QUERY) |=> !in_ch.ready)
    else $error("input ready right after a query was accepted");

endmodule

// ----- hw/rtl/twcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// twcc_ctrl
// Sequencer: clearing pass after reset, request acceptance, query setup,
// tile scan, pipeline drain and result hand-off.
// ----------------------------------------------------------------------------
module twcc_ctrl import twcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_mode,
  input  twcc_sts_t sts,
  output twcc_cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_BOUND = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.accept_en = 1'b1;
        if (in_valid && in_mode == MODE_QUERY) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup_en = 1'b1;
        state_nxt    = ST_BOUND;
      end
      ST_BOUND: begin
        cmd.load_bounds = 1'b1;
        state_nxt       = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.empty) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_result = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/twcc_datapath.sv -----
// ----------------------------------------------------------------------------
// twcc_datapath
// Wall store, thickness register, scan window, four-stage slab test pipeline
// and output register.
// ----------------------------------------------------------------------------
module twcc_datapath import twcc_pkg::*; #(
  parameter int GRID_SIZE = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  twcc_cmd_t               cmd,
  output twcc_sts_t               sts,
  input  logic                    in_accept,
  input  logic                    in_mode,
  input  logic [TILE_W-1:0]       in_tile_row,
  input  logic [TILE_W-1:0]       in_tile_col,
  input  logic [WALLS_W-1:0]      in_tile_walls,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic [RAD_W-1:0]        in_circle_radius,
  input  logic                    cfg_wr_en,
  input  logic [THICK_W-1:0]      cfg_wr_data,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    out_hit
);

  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(GRID_SIZE);
  localparam int FW    = POS_W + 2;
  localparam int CW    = ((IW + FRAC_BITS > POS_W) ? IW + FRAC_BITS : POS_W) + 3;
  // Distances from the centre to any slab of a scanned tile stay below
  // radius + two tiles + thickness, which this width covers.
  localparam int DXW   = (FRAC_BITS + 3 > 13) ? FRAC_BITS + 3 : 13;
  localparam int SQW   = 2 * DXW;

  localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);
  localparam logic signed [FW-1:0] GMAX      = FW'(GRID_SIZE - 1);
  localparam logic signed [CW-1:0] TILE_ONE  = CW'(1) <<< FRAC_BITS;

  // ---------------- configuration ----------------
  logic [THICK_W-1:0] thick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thick_r <= THICK_RESET;
    end else if (cfg_wr_en) begin
      thick_r <= cfg_wr_data;
    end
  end

  // ---------------- wall store ----------------
  logic [WALLS_W-1:0] mem [DEPTH];
  logic [AW-1:0]      clr_cnt_r;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [WALLS_W-1:0] wr_data;
  logic               wr_in_grid;

  assign wr_in_grid = (9'(in_tile_row) < 9'(GRID_SIZE)) && (9'(in_tile_col) < 9'(GRID_SIZE));

  always_comb begin
    if (cmd.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else begin
      wr_en   = in_accept && (in_mode == MODE_WRITE) && wr_in_grid;
      wr_addr = AW'(in_tile_row) * AW'(GRID_SIZE) + AW'(in_tile_col);
      wr_data = in_tile_walls;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign sts.clear_done = (clr_cnt_r == LAST_ADDR);

  // ---------------- query setup ----------------
  logic signed [POS_W-1:0] x_r;
  logic signed [POS_W-1:0] z_r;
  logic [RAD_W-1:0]        rad_r;
  logic [R2_W-1:0]         r2_r;
  logic signed [FW-1:0]    fl_clo_r, fl_chi_r, fl_rlo_r, fl_rhi_r;
  logic signed [FW-1:0]    xs, zs, rs;

  always_ff @(posedge clk) begin
    if (in_accept && in_mode == MODE_QUERY) begin
      x_r   <= in_pos_x;
      z_r   <= in_pos_z;
      rad_r <= in_circle_radius;
    end
  end

  assign xs = FW'(x_r);
  assign zs = FW'(z_r);
  assign rs = $signed(FW'(rad_r));

  always_ff @(posedge clk) begin
    if (cmd.setup_en) begin
      r2_r     <= R2_W'(rad_r) * R2_W'(rad_r);
      fl_clo_r <= ((xs - rs) >>> FRAC_BITS) - FW'(1);
      fl_chi_r <= ((xs + rs) >>> FRAC_BITS) + FW'(1);
      fl_rlo_r <= ((zs - rs) >>> FRAC_BITS) - FW'(1);
      fl_rhi_r <= ((zs + rs) >>> FRAC_BITS) + FW'(1);
    end
  end

  // ---------------- scan window and counters ----------------
  logic signed [FW-1:0] clo, chi, rlo, rhi;
  logic [IW-1:0]        c_lo_r, c_hi_r, r_hi_r, col_r, row_r;
  logic                 empty_r;

  always_comb begin
    clo = (fl_clo_r < 0) ? '0 : fl_clo_r;
    rlo = (fl_rlo_r < 0) ? '0 : fl_rlo_r;
    chi = (fl_chi_r > GMAX) ? GMAX : fl_chi_r;
    rhi = (fl_rhi_r > GMAX) ? GMAX : fl_rhi_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_bounds) begin
      empty_r <= (clo > chi) || (rlo > rhi);
      c_lo_r  <= clo[IW-1:0];
      c_hi_r  <= chi[IW-1:0];
      r_hi_r  <= rhi[IW-1:0];
      col_r   <= clo[IW-1:0];
      row_r   <= rlo[IW-1:0];
    end else if (cmd.scan_step) begin
      if (col_r == c_hi_r) begin
        col_r <= c_lo_r;
        row_r <= row_r + IW'(1);
      end else begin
        col_r <= col_r + IW'(1);
      end
    end
  end

  assign sts.empty     = empty_r;
  assign sts.scan_last = (col_r == c_hi_r) && (row_r == r_hi_r);

  // ---------------- stage 1: store read and slab edges ----------------
  logic [AW-1:0]        rd_addr;
  logic signed [CW-1:0] ax, az, tee;
  logic                 v1_r;
  logic [WALLS_W-1:0]   walls1_r;
  logic signed [CW-1:0] xa_m_r, xa_p_r, xb_m_r, xb_p_r;
  logic signed [CW-1:0] za_m_r, za_p_r, zb_m_r, zb_p_r;

  assign rd_addr = AW'(row_r) * AW'(GRID_SIZE) + AW'(col_r);
  assign ax      = $signed(CW'(col_r)) <<< FRAC_BITS;
  assign az      = $signed(CW'(row_r)) <<< FRAC_BITS;
  assign tee     = $signed(CW'(thick_r));

  always_ff @(posedge clk) begin
    if (cmd.scan_step) walls1_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      xa_m_r <= ax - tee;
      xa_p_r <= ax + tee;
      xb_m_r <= ax + TILE_ONE - tee;
      xb_p_r <= ax + TILE_ONE + tee;
      za_m_r <= az - tee;
      za_p_r <= az + tee;
      zb_m_r <= az + TILE_ONE - tee;
      zb_p_r <= az + TILE_ONE + tee;
    end
  end

  // ---------------- stage 2: clamp distances ----------------
  function automatic logic signed [DXW-1:0] axis_gap(input logic signed [CW-1:0] p,
                                                     input logic signed [CW-1:0] lo,
                                                     input logic signed [CW-1:0] hi);
    logic signed [CW-1:0] dl;
    logic signed [CW-1:0] dh;
    dl = p - lo;
    dh = p - hi;
    if (dl < 0) return dl[DXW-1:0];
    else if (dh > 0) return dh[DXW-1:0];
    else return '0;
  endfunction

  logic signed [CW-1:0]  xc, zc;
  logic                  v2_r;
  logic [WALLS_W-1:0]    walls2_r;
  logic signed [DXW-1:0] dx_ns_r, dx_w_r, dx_e_r, dz_n_r, dz_s_r, dz_we_r;

  assign xc = CW'(x_r);
  assign zc = CW'(z_r);

  always_ff @(posedge clk) begin
    if (v1_r) begin
      walls2_r <= walls1_r;
      dx_ns_r  <= axis_gap(xc, xa_m_r, xb_p_r);
      dx_w_r   <= axis_gap(xc, xa_m_r, xa_p_r);
      dx_e_r   <= axis_gap(xc, xb_m_r, xb_p_r);
      dz_n_r   <= axis_gap(zc, za_m_r, za_p_r);
      dz_s_r   <= axis_gap(zc, zb_m_r, zb_p_r);
      dz_we_r  <= axis_gap(zc, za_m_r, zb_p_r);
    end
  end

  // ---------------- stage 3: squares ----------------
  logic               v3_r;
  logic [WALLS_W-1:0] walls3_r;
  logic [SQW-1:0]     sx_ns_r, sx_w_r, sx_e_r, sz_n_r, sz_s_r, sz_we_r;

  always_ff @(posedge clk) begin
    if (v2_r) begin
      walls3_r <= walls2_r;
      sx_ns_r  <= SQW'(dx_ns_r) * SQW'(dx_ns_r);
      sx_w_r   <= SQW'(dx_w_r) * SQW'(dx_w_r);
      sx_e_r   <= SQW'(dx_e_r) * SQW'(dx_e_r);
      sz_n_r   <= SQW'(dz_n_r) * SQW'(dz_n_r);
      sz_s_r   <= SQW'(dz_s_r) * SQW'(dz_s_r);
      sz_we_r  <= SQW'(dz_we_r) * SQW'(dz_we_r);
    end
  end

  // ---------------- stage 4: compare and accumulate ----------------
  logic [SQW:0]       r2_ext;
  logic [WALLS_W-1:0] near;
  logic               hit_acc_r;

  assign r2_ext = (SQW + 1)'(r2_r);

  always_comb begin
    near         = '0;
    near[WALL_N] = ((SQW + 1)'(sx_ns_r) + (SQW + 1)'(sz_n_r)) < r2_ext;
    near[WALL_S] = ((SQW + 1)'(sx_ns_r) + (SQW + 1)'(sz_s_r)) < r2_ext;
    near[WALL_W] = ((SQW + 1)'(sx_w_r) + (SQW + 1)'(sz_we_r)) < r2_ext;
    near[WALL_E] = ((SQW + 1)'(sx_e_r) + (SQW + 1)'(sz_we_r)) < r2_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      hit_acc_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_step;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (in_accept && in_mode == MODE_QUERY) begin
        hit_acc_r <= 1'b0;
      end else if (v3_r && |(walls3_r & near)) begin
        hit_acc_r <= 1'b1;
      end
    end
  end

  assign sts.pipe_busy = v1_r || v2_r || v3_r;

  // ---------------- output register ----------------
  logic out_valid_r;
  logic out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) out_hit_r <= hit_acc_r;
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;

endmodule

// ----- sim/twcc_hit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcc_hit_checker
// Passive checker for the tile wall circle collision core. It keeps its own
// copy of the wall grid and the slab half thickness. For every accepted query
// it computes the expected hit flag, and it compares each accepted result with
// the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module twcc_hit_checker import twcc_pkg::*; #(
  parameter int GRID_SIZE = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  twcc_in_if                 in_mon,
  twcc_out_if                out_mon,
  input  logic               cfg_wr_en,
  input  logic [THICK_W-1:0] cfg_wr_data,
  output int                 error_count,
  output int                 hits_pending
);

  logic [WALLS_W-1:0] wall_map [GRID_SIZE*GRID_SIZE];
  logic [THICK_W-1:0] half_thick;
  logic               hit_q [$];
  int                 errs;

  function automatic logic slab_touch(input longint x, input longint z, input longint r2,
                                      input longint x0, input longint z0,
                                      input longint x1, input longint z1);
    longint dx;
    longint dz;
    dx = x - ((x < x0) ? x0 : ((x > x1) ? x1 : x));
    dz = z - ((z < z0) ? z0 : ((z > z1) ? z1 : z));
    return (dx * dx + dz * dz) < r2;
  endfunction

  function automatic logic circle_hits_wall(input longint x, input longint z,
                                            input longint r);
    longint             one;
    longint             t;
    longint             r2;
    longint             c_lo, c_hi, r_lo, r_hi;
    longint             row, col;
    longint             ax, az, bx, bz;
    logic [WALLS_W-1:0] w;
    logic               found;
    one   = longint'(1) << FRAC_BITS;
    t     = longint'(half_thick);
    r2    = r * r;
    found = 1'b0;
    // Arithmetic shift of a signed value rounds toward minus infinity.
    c_lo = ((x - r) >>> FRAC_BITS) - 1;
    c_hi = ((x + r) >>> FRAC_BITS) + 1;
    r_lo = ((z - r) >>> FRAC_BITS) - 1;
    r_hi = ((z + r) >>> FRAC_BITS) + 1;
    if (c_lo < 0) c_lo = 0;
    if (r_lo < 0) r_lo = 0;
    if (c_hi > GRID_SIZE - 1) c_hi = GRID_SIZE - 1;
    if (r_hi > GRID_SIZE - 1) r_hi = GRID_SIZE - 1;
    for (row = r_lo; row <= r_hi && !found; row++) begin
      for (col = c_lo; col <= c_hi && !found; col++) begin
        w  = wall_map[row * GRID_SIZE + col];
        ax = col * one;
        az = row * one;
        bx = ax + one;
        bz = az + one;
        if (w[WALL_N] && slab_touch(x, z, r2, ax - t, az - t, bx + t, az + t)) found = 1'b1;
        if (w[WALL_S] && slab_touch(x, z, r2, ax - t, bz - t, bx + t, bz + t)) found = 1'b1;
        if (w[WALL_W] && slab_touch(x, z, r2, ax - t, az - t, ax + t, bz + t)) found = 1'b1;
        if (w[WALL_E] && slab_touch(x, z, r2, bx - t, az - t, bx + t, bz + t)) found = 1'b1;
      end
    end
    return found;
  endfunction

  always @(posedge clk) begin : track
    logic want;
    if (!rst_n) begin
      for (int i = 0; i < GRID_SIZE * GRID_SIZE; i++) wall_map[i] = '0;
      half_thick = THICK_RESET;
      hit_q.delete();
      errs = 0;
    end else begin
      if (cfg_wr_en) half_thick = cfg_wr_data;
      // Results are retired before new queries are queued, so a result and a
      // request on the same edge never pair up with each other.
      if (out_mon.valid && out_mon.ready) begin
        if (hit_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none, actual hit=%0b",
                   $time, out_mon.hit);
        end else begin
          want = hit_q.pop_front();
          if (out_mon.hit !== want) begin
            errs++;
            $display("%0t: hit mismatch, expected %0b, actual %0b",
                     $time, want, out_mon.hit);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.mode == MODE_WRITE) begin
          if (int'(in_mon.tile_row) < GRID_SIZE && int'(in_mon.tile_col) < GRID_SIZE)
            wall_map[int'(in_mon.tile_row) * GRID_SIZE + int'(in_mon.tile_col)] =
              in_mon.tile_walls;
        end else begin
          hit_q.push_back(circle_hits_wall(longint'(in_mon.pos_x), longint'(in_mon.pos_z),
                                           longint'(in_mon.circle_radius)));
        end
      end
    end
    error_count  <= errs;
    hits_pending <= hit_q.size();
  end

endmodule

// ----- sim/tile_wall_circle_collision_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_wall_circle_collision_core_tb
// Drives wall writes and circle queries into the collision core: a directed
// set of edge and boundary cases, then random traffic clustered around a few
// grid windows, under several sender and receiver throttling phases and slab
// thickness settings. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tile_wall_circle_collision_core_tb;
  import twcc_pkg::*;

  localparam int GRID_SIZE      = 64;
  localparam int FRAC_BITS      = 8;
  localparam int ONE            = 1 << FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEMS_PER_RUN  = 300;

  typedef struct {
    logic                    mode;
    logic [TILE_W-1:0]       row;
    logic [TILE_W-1:0]       col;
    logic [WALLS_W-1:0]      walls;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] z;
    logic [RAD_W-1:0]        r;
  } twcc_req_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [THICK_W-1:0] cfg_wr_data;
  int                 check_errors;
  int                 hits_pending;
  int                 send_idle_pct;
  int                 recv_stall_pct;

  twcc_in_if  in_ch ();
  twcc_out_if out_ch ();

  tile_wall_circle_collision_core #(
    .GRID_SIZE (GRID_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  twcc_hit_checker #(
    .GRID_SIZE (GRID_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .error_count  (check_errors),
    .hits_pending (hits_pending)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = 1'b1;
      #5 clk = 1'b0;
    end
  end

  // Result side throttling.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Ends the run if no request and no result moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic twcc_req_t noise_req();
    twcc_req_t rq;
    rq.mode  = 1'($urandom_range(1));
    rq.row   = TILE_W'($urandom_range(GRID_SIZE - 1));
    rq.col   = TILE_W'($urandom_range(GRID_SIZE - 1));
    rq.walls = WALLS_W'($urandom_range(15));
    rq.x     = POS_W'($urandom_range(16'hFFFF));
    rq.z     = POS_W'($urandom_range(16'hFFFF));
    rq.r     = RAD_W'($urandom_range(10'h3FF));
    return rq;
  endfunction

  function automatic twcc_req_t mk_write(input int row, input int col, input int walls);
    twcc_req_t rq;
    rq       = noise_req();
    rq.mode  = MODE_WRITE;
    rq.row   = TILE_W'(row);
    rq.col   = TILE_W'(col);
    rq.walls = WALLS_W'(walls);
    return rq;
  endfunction

  function automatic twcc_req_t mk_query(input int x, input int z, input int r);
    twcc_req_t rq;
    rq      = noise_req();
    rq.mode = MODE_QUERY;
    rq.x    = POS_W'(x);
    rq.z    = POS_W'(z);
    rq.r    = RAD_W'(r);
    return rq;
  endfunction

  // Most traffic lands in or near a 6x6 tile window at one of three grid spots, so
  // that queries regularly meet written walls, including at the grid border.
  function automatic twcc_req_t random_req();
    twcc_req_t rq;
    int        base;
    int        pick;
    int        x, z, r;
    case ($urandom_range(2))
      0:       base = 0;
      1:       base = 29;
      default: base = GRID_SIZE - 6;
    endcase
    pick = $urandom_range(99);
    if (pick < 30) begin
      rq = mk_write(base + $urandom_range(5), base + $urandom_range(5),
                    ($urandom_range(3) == 0) ? 0 : $urandom_range(15));
    end else if (pick < 38) begin
      rq      = noise_req();
      rq.mode = MODE_WRITE;
    end else if (pick < 88) begin
      x    = base * ONE + $urandom_range(6 * ONE + 1024) - 512;
      z    = base * ONE + $urandom_range(6 * ONE + 1024) - 512;
      pick = $urandom_range(99);
      if (pick < 8)       r = 0;
      else if (pick < 14) r = 512;
      else if (pick < 20) r = $urandom_range(1023, 513);
      else                r = $urandom_range(512, 1);
      // Coarse values make exact touching distances far more likely.
      if ($urandom_range(3) == 0) begin
        x = x & ~15;
        z = z & ~15;
        r = r & ~15;
      end
      rq = mk_query(x, z, r);
    end else begin
      rq      = noise_req();
      rq.mode = MODE_QUERY;
    end
    return rq;
  endfunction

  task automatic send_req(input twcc_req_t rq);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= rq.mode;
    in_ch.tile_row      <= rq.row;
    in_ch.tile_col      <= rq.col;
    in_ch.tile_walls    <= rq.walls;
    in_ch.pos_x         <= rq.x;
    in_ch.pos_z         <= rq.z;
    in_ch.circle_radius <= rq.r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (hits_pending != 0) @(posedge clk);
  endtask

  task automatic set_thickness(input logic [THICK_W-1:0] value);
    drain_results();
    // A trailing wall write has no result to wait for; let it settle.
    repeat (80) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    twcc_req_t          directed [$];
    int                 idle_by_run  [4];
    int                 stall_by_run [4];
    logic [THICK_W-1:0] thick_by_run [4];

    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_WRITE;
    in_ch.tile_row      = '0;
    in_ch.tile_col      = '0;
    in_ch.tile_walls    = '0;
    in_ch.pos_x         = '0;
    in_ch.pos_z         = '0;
    in_ch.circle_radius = '0;
    idle_by_run         = '{0, 67, 0, 14};
    stall_by_run        = '{0, 0, 67, 14};
    thick_by_run        = '{8'd0, 8'd128, 8'd255, THICK_W'($urandom_range(128))};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the reset thickness of 16.
    directed.push_back(mk_write(0, 0, 15));
    directed.push_back(mk_write(GRID_SIZE - 1, GRID_SIZE - 1, 15));
    directed.push_back(mk_write(20, 10, 1 << WALL_N));
    directed.push_back(mk_write(20, 14, 1 << WALL_S));
    directed.push_back(mk_write(24, 10, 1 << WALL_W));
    directed.push_back(mk_write(24, 14, 1 << WALL_E));
    directed.push_back(mk_query(0, 0, 0));
    directed.push_back(mk_query(0, 0, 512));
    directed.push_back(mk_query(-32768, -32768, 512));
    directed.push_back(mk_query(32767, 32767, 1023));
    directed.push_back(mk_query(63 * ONE + 128, 63 * ONE + 128, 1));
    // Each wall side, first at exactly the radius (a miss), then one closer.
    directed.push_back(mk_query(2688, 5054, 50));
    directed.push_back(mk_query(2688, 5054, 51));
    directed.push_back(mk_query(3712, 5432, 40));
    directed.push_back(mk_query(3712, 5432, 41));
    directed.push_back(mk_query(2514, 6272, 30));
    directed.push_back(mk_query(2514, 6272, 31));
    directed.push_back(mk_query(3876, 6272, 20));
    directed.push_back(mk_query(3876, 6272, 21));
    // Diagonal approach to the outer corner of tile (0,0).
    directed.push_back(mk_query(-46, -56, 50));
    directed.push_back(mk_query(-46, -56, 51));
    // A cleared tile must no longer hit.
    directed.push_back(mk_write(20, 10, 0));
    directed.push_back(mk_query(2688, 5054, 51));
    directed.push_back(mk_query(32 * ONE, 32 * ONE, 1023));
    foreach (directed[i]) send_req(directed[i]);

    for (int run = 0; run < 4; run++) begin
      set_thickness(thick_by_run[run]);
      send_idle_pct  = idle_by_run[run];
      recv_stall_pct = stall_by_run[run];
      for (int n = 0; n < ITEMS_PER_RUN; n++) begin
        send_req(random_req());
        if ($urandom_range(99) == 0) drain_results();
      end
    end

    drain_results();
    repeat (150) @(posedge clk);
    if (check_errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
